FILE: design/socc_pkg.sv
// Shared constants, types and helper functions for the substring occurrence counter.
`timescale 1ns / 1ps
`default_nettype none

package socc_pkg;

  // Pattern storage and field widths.
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int LEN_W             = 5;
  localparam int BYTE_W            = 8;
  localparam int CNT_W             = 16;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_ADDR_W        = 5;
  localparam int OUT_TDATA_W       = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register index, taken from paddr[4:3] since registers sit on 8-byte strides.
  typedef enum logic [1:0] {
    REG_PATTERN_FIRST = 2'd0,
    REG_PATTERN_LAST  = 2'd1,
    REG_PATTERN_LEN   = 2'd2
  } reg_idx_t;

  typedef logic [BYTE_W-1:0] pat_bytes_t [MAX_PATTERN_BYTES];

  // Outcome of matching one text byte.
  typedef struct packed {
    logic                         hit;
    logic [MAX_PATTERN_BYTES-1:0] partial;
  } match_res_t;

  // Fold ASCII A-Z to lower case; all other bytes pass unchanged.
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/socc_match.sv
// Bit-parallel shift-and update of the partial-match vector for one text byte.
`timescale 1ns / 1ps
`default_nettype none

module socc_match (
  input  wire logic [socc_pkg::BYTE_W-1:0]            text_byte,
  input  wire socc_pkg::pat_bytes_t                   pattern,
  input  wire logic [socc_pkg::LEN_W-1:0]             pattern_len,
  input  wire logic [socc_pkg::MAX_PATTERN_BYTES-1:0] partial,
  output socc_pkg::match_res_t                        res
);
  import socc_pkg::*;

  logic [BYTE_W-1:0]            ch;
  logic [LEN_W-1:0]             len_c;
  logic [MAX_PATTERN_BYTES-1:0] eq;
  logic [MAX_PATTERN_BYTES-1:0] last_lane;
  logic [MAX_PATTERN_BYTES-1:0] shifted;

  always_comb begin
    ch = fold_case(text_byte);
    // Lengths beyond the pattern store count as a full pattern.
    len_c = (pattern_len > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES)
                                                       : pattern_len;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      eq[i]        = (LEN_W'(i) < len_c) && (fold_case(pattern[i]) == ch);
      last_lane[i] = (len_c == LEN_W'(i + 1));
    end
    shifted = {partial[MAX_PATTERN_BYTES-2:0], 1'b1} & eq;
    res.hit = |(shifted & last_lane);
    // A complete match restarts the search right after it.
    res.partial = res.hit ? '0 : shifted;
  end

endmodule

`default_nettype wire

FILE: design/substring_occurrence_counter.sv
// Top level of the case-insensitive, non-overlapping substring occurrence counter.
// An item is registered on acceptance and matched from that register; a document's result
// is written to the output register when its last item leaves the input register.
// Throughput: one item per cycle, set by the shift-and update loop on
// the partial-match vector; the only stall is a held result blocking another last item.
// Reset (synchronous, active low) clears the pattern registers, the partial matches,
// the running count, the document index and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module substring_occurrence_counter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream. tdata: [7:0] text_byte. tlast: document_end.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [socc_pkg::BYTE_W-1:0]       in_tdata,
  input  wire logic                              in_tlast,
  // Result stream. tdata: [15:0] document_index, [31:16] match_count, [32] found,
  // [39:33] zero.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [socc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // Configuration port.
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [socc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [socc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [socc_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);
  import socc_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pat_first_r;
  logic [CFG_DATA_W-1:0] pat_last_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  // Input register stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              in_acc;

  // Matching state.
  logic [MAX_PATTERN_BYTES-1:0] partial_r;
  logic [MAX_PATTERN_BYTES-1:0] partial_nxt;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [CNT_W-1:0]             count_hit;
  logic [CNT_W-1:0]             doc_idx_r;
  logic [CNT_W-1:0]             doc_idx_nxt;

  // Result register.
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  pat_bytes_t pattern;
  match_res_t mres;

  // ---------------------------------------------------------------------------
  // Configuration port: pready is tied high, so every access cycle completes.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_first_r <= '0;
      pat_last_r  <= '0;
      pat_len_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PATTERN_FIRST: pat_first_r <= cfg_pwdata;
        REG_PATTERN_LAST:  pat_last_r  <= cfg_pwdata;
        REG_PATTERN_LEN:   pat_len_r   <= cfg_pwdata[LEN_W-1:0];
        default: ;  // Unused address: the write is dropped.
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PATTERN_FIRST: cfg_prdata = pat_first_r;
      REG_PATTERN_LAST:  cfg_prdata = pat_last_r;
      REG_PATTERN_LEN:   cfg_prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, pat_len_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // Split the two pattern words into a byte array; the low word holds bytes 0..7.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (i < 8) begin
        pattern[i] = pat_first_r[(i % 8) * BYTE_W +: BYTE_W];
      end else begin
        pattern[i] = pat_last_r[(i % 8) * BYTE_W +: BYTE_W];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. An item without the document mark never needs the result
  // register, so it always moves on. A marked item moves on when the result
  // register is free or is being emptied this cycle.
  // ---------------------------------------------------------------------------
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Match update for the registered item.
  // ---------------------------------------------------------------------------
  socc_match u_match (
    .text_byte   (s1_byte_r),
    .pattern     (pattern),
    .pattern_len (pat_len_r),
    .partial     (partial_r),
    .res         (mres)
  );

  always_comb begin
    // The count saturates rather than wrapping.
    count_hit = (mres.hit && count_r != CNT_MAX) ? count_r + 1'b1 : count_r;

    partial_nxt   = partial_r;
    count_nxt     = count_r;
    doc_idx_nxt   = doc_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (s1_adv) begin
      if (s1_last_r) begin
        // End of document: the result goes out and the per-document state restarts.
        partial_nxt   = '0;
        count_nxt     = '0;
        doc_idx_nxt   = doc_idx_r + 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        partial_nxt = mres.partial;
        count_nxt   = count_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      count_r     <= '0;
      doc_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      partial_r   <= partial_nxt;
      count_r     <= count_nxt;
      doc_idx_r   <= doc_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= {{(OUT_TDATA_W-2*CNT_W-1){1'b0}}, (count_hit != '0), count_hit,
                     doc_idx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: test/substring_occurrence_counter_test.sv
// Self-checking testbench for the substring occurrence counter: random text against a predictor.
`timescale 1ns / 1ps

module substring_occurrence_counter_test;
  import socc_pkg::*;

  // The run is ended by force if it gets this far; the slowest correct run, with the longest
  // gaps and stalls on every item, needs well under a quarter of it.
  localparam int CYCLE_LIMIT = 400_000;
  // The block registers an item, matches it from that register and registers a document's
  // result when its last item leaves that register, so this many quiet cycles is plenty.
  localparam int SETTLE_CYCLES = 8;
  // A register index that maps to nothing; writes to it must be ignored.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // One text item as queued for the driver. drain_first holds the item back until every
  // outstanding document result has been received.
  typedef struct {
    logic [BYTE_W-1:0] text_byte;
    logic              doc_end;
    bit                drain_first;
  } text_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] doc_index;
    logic [CNT_W-1:0] count;
    logic             found;
  } doc_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  substring_occurrence_counter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [7:0] text_byte
    .in_tlast    (in_tlast),    // document_end
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [15:0] document_index, [31:16] match_count, [32] found
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Stimulus and expectations.
  text_item_t  text_backlog[$];
  doc_result_t doc_results_due[$];

  // Shadow copy of the configuration registers and of the matcher state.
  logic [CFG_DATA_W-1:0]        pat_first_shadow = '0;
  logic [CFG_DATA_W-1:0]        pat_last_shadow = '0;
  logic [LEN_W-1:0]             pat_len_shadow = '0;
  logic [MAX_PATTERN_BYTES-1:0] prefix_hits = '0;
  logic [CNT_W-1:0]             doc_match_count = '0;
  logic [CNT_W-1:0]             doc_number = '0;

  // Handshake bookkeeping shared between the clocked blocks.
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  bit          full_rate = 1'b0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          tx_wait = 0;
  int          rx_stall = 0;
  text_item_t  cur;
  doc_result_t want;
  doc_result_t got;

  int errors = 0;
  int cycle_count = 0;
  int items_taken = 0;
  int documents_done = 0;
  int found_docs = 0;
  int cfg_writes = 0;

  function automatic logic [BYTE_W-1:0] lower_ascii(input logic [BYTE_W-1:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  endfunction

  // Randomly swaps the case of a letter so that case folding gets exercised on both sides.
  function automatic logic [BYTE_W-1:0] case_flip(input logic [BYTE_W-1:0] b);
    if (((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) && $urandom_range(0, 1)) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Predicts the effect of one accepted text item. The pattern is matched shift-and style over
  // the active length; a full match bumps the count and clears every partial match, which
  // yields the leftmost non-overlapping count. A marked item closes the document.
  task automatic scan_byte(input logic [BYTE_W-1:0] raw, input logic doc_end);
    logic [BYTE_W-1:0]            ch;
    logic [BYTE_W-1:0]            pb;
    logic [MAX_PATTERN_BYTES-1:0] hits;
    doc_result_t                  r;
    int                           span;
    int                           i;
    ch = lower_ascii(raw);
    span = (pat_len_shadow > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len_shadow);
    if (span == 0) begin
      prefix_hits = '0;
    end else begin
      hits = '0;
      for (i = 0; i < span; i++) begin
        pb = (i < 8) ? pat_first_shadow[i*8 +: 8] : pat_last_shadow[(i-8)*8 +: 8];
        hits[i] = (lower_ascii(pb) == ch);
      end
      prefix_hits = {prefix_hits[MAX_PATTERN_BYTES-2:0], 1'b1} & hits;
      if (prefix_hits[span-1]) begin
        if (doc_match_count != CNT_MAX) begin
          doc_match_count++;
        end
        prefix_hits = '0;
      end
    end
    if (doc_end) begin
      r = '{doc_number, doc_match_count, doc_match_count != '0};
      doc_results_due.insert(doc_results_due.size(), r);
      if (r.found) begin
        found_docs++;
      end
      documents_done++;
      prefix_hits = '0;
      doc_match_count = '0;
      doc_number++;
    end
  endtask

  task automatic flag_bad_result(input string why, input doc_result_t w, input doc_result_t g);
    errors++;
    if (errors <= 10) begin
      $display("mismatch (%s) at cycle %0d: expected index %0d count %0d found %0b,",
               why, cycle_count, w.doc_index, w.count, w.found);
      $display("  got index %0d count %0d found %0b (raw %h)",
               g.doc_index, g.count, g.found, out_tdata);
    end
  endtask

  // Sender: presents queued items, holding each until it is taken, with a random gap after it.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_taken)) begin
      if (tx_wait > 0) begin
        in_tvalid <= 1'b0;
        tx_wait--;
      end else if (text_backlog.size() != 0 &&
                   !(text_backlog[0].drain_first && doc_results_due.size() != 0)) begin
        cur = text_backlog.pop_front();
        in_tdata  <= cur.text_byte;
        in_tlast  <= cur.doc_end;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 59) == 0) begin
          tx_burst = !tx_burst;
        end
        tx_wait = draw_gap(full_rate || tx_burst);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: after every result it takes, it stalls for a random number of cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 59) == 0) begin
          rx_burst = !rx_burst;
        end
        rx_stall = draw_gap(full_rate || rx_burst);
      end
      if (rx_stall > 0) begin
        out_tready <= 1'b0;
        rx_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Sampling at the rising edge: predict on every taken item, check every taken result.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) begin
        items_taken++;
        scan_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        got.doc_index = out_tdata[CNT_W-1:0];
        got.count     = out_tdata[2*CNT_W-1:CNT_W];
        got.found     = out_tdata[2*CNT_W];
        if (doc_results_due.size() == 0) begin
          flag_bad_result("no result due", '0, got);
        end else begin
          want = doc_results_due.pop_front();
          if (got !== want || out_tdata[OUT_TDATA_W-1:2*CNT_W+1] !== '0) begin
            flag_bad_result("wrong field", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               doc_results_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle until pready is seen.
  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= d;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_PATTERN_FIRST: pat_first_shadow = d;
      REG_PATTERN_LAST:  pat_last_shadow  = d;
      REG_PATTERN_LEN:   pat_len_shadow   = d[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [BYTE_W-1:0] b, input logic doc_end, input bit drain);
    text_item_t it;
    it.text_byte   = b;
    it.doc_end     = doc_end;
    it.drain_first = drain;
    text_backlog.insert(text_backlog.size(), it);
  endtask

  // Waits until every queued item is taken and every due result has come back, then lets the
  // pipeline run dry, since a trailing unmarked item produces no result to wait for.
  task automatic settle();
    while (text_backlog.size() != 0 || in_tvalid || doc_results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A phase of random documents under a fresh random pattern. Most of the text is built from
  // copies and prefixes of the pattern with random case, so that matches, overlaps and
  // near misses are frequent; the rest is pattern bytes and arbitrary bytes as noise.
  task automatic random_phase(input int n_items, input bit full_length);
    logic [BYTE_W-1:0]     pat [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0]     doc [$];
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [LEN_W-1:0]      len_reg;
    int                    style;
    int                    pick;
    int                    plen;
    int                    left;
    int                    dlen;
    int                    chunk;
    int                    cut;
    int                    k;
    int                    j;
    settle();
    style = $urandom_range(0, 3);
    for (k = 0; k < MAX_PATTERN_BYTES; k++) begin
      case (style)
        0:       pat[k] = BYTE_W'($urandom_range(0, 255));
        1:       pat[k] = case_flip($urandom_range(0, 1) ? 8'h61 : 8'h62);
        default: pat[k] = case_flip(BYTE_W'(8'h61 + $urandom_range(0, 25)));
      endcase
      if (k < 8) begin
        lo[k*8 +: 8] = pat[k];
      end else begin
        hi[(k-8)*8 +: 8] = pat[k];
      end
    end
    pick = $urandom_range(0, 15);
    if (full_length || pick == 1) begin
      len_reg = LEN_W'(MAX_PATTERN_BYTES);
    end else if (pick == 0) begin
      len_reg = '0;
    end else if (pick == 2) begin
      len_reg = LEN_W'($urandom_range(MAX_PATTERN_BYTES + 1, 31));
    end else if (pick < 6) begin
      len_reg = LEN_W'($urandom_range(7, MAX_PATTERN_BYTES - 1));
    end else begin
      len_reg = LEN_W'($urandom_range(1, 6));
    end
    cfg_write(REG_PATTERN_FIRST, lo);
    cfg_write(REG_PATTERN_LAST, hi);
    cfg_write(REG_PATTERN_LEN, CFG_DATA_W'(len_reg));
    plen = (len_reg > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(len_reg);
    left = n_items;
    while (left > 0) begin
      doc = {};
      dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      while (doc.size() < dlen) begin
        chunk = $urandom_range(0, 9);
        if (plen > 0 && chunk < 4) begin
          for (j = 0; j < plen; j++) begin
            doc.insert(doc.size(), case_flip(pat[j]));
          end
        end else if (plen > 1 && chunk < 6) begin
          cut = $urandom_range(1, plen - 1);
          for (j = 0; j < cut; j++) begin
            doc.insert(doc.size(), case_flip(pat[j]));
          end
        end else if (chunk < 8) begin
          doc.insert(doc.size(), case_flip(pat[$urandom_range(0, MAX_PATTERN_BYTES - 1)]));
        end else begin
          doc.insert(doc.size(), BYTE_W'($urandom_range(0, 255)));
        end
      end
      for (j = 0; j < doc.size(); j++) begin
        push_item(doc[j], j == doc.size() - 1, j == 0 && $urandom_range(0, 29) == 0);
      end
      left -= doc.size();
    end
    // Sometimes leave a document open with a partial match in flight, so the next phase
    // changes the pattern in the middle of it.
    if ($urandom_range(0, 2) == 0) begin
      cut = $urandom_range(1, 4);
      for (j = 0; j < cut; j++) begin
        push_item(case_flip(pat[j]), 1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    int k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Out of reset the pattern is empty, so nothing can match.
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    settle();

    // Pattern "aBa" against "ABABA": the match at the start consumes the shared 'a', so a
    // second, overlapping occurrence must not be counted.
    cfg_write(REG_PATTERN_FIRST, 64'h0000_0000_0061_4261);
    cfg_write(REG_PATTERN_LEN, 64'd3);
    push_item(8'h41, 1'b0, 1'b0);
    push_item(8'h42, 1'b0, 1'b0);
    push_item(8'h41, 1'b0, 1'b0);
    push_item(8'h42, 1'b0, 1'b0);
    push_item(8'h41, 1'b1, 1'b0);
    settle();

    // Folding stops at the edges of A-Z: '`' is not '@' in another case.
    cfg_write(REG_UNMAPPED, 64'hdead_beef_dead_beef);
    cfg_write(REG_PATTERN_FIRST, 64'h0000_0000_0000_405a);
    cfg_write(REG_PATTERN_LEN, 64'd2);
    push_item(8'h7a, 1'b0, 1'b1);
    push_item(8'h60, 1'b0, 1'b0);
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'h40, 1'b1, 1'b0);
    settle();

    // All-ones and all-zero pattern words with an oversized length, which acts as the full
    // sixteen bytes.
    cfg_write(REG_PATTERN_FIRST, '1);
    cfg_write(REG_PATTERN_LAST, '0);
    cfg_write(REG_PATTERN_LEN, 64'd31);
    for (k = 0; k < MAX_PATTERN_BYTES; k++) begin
      push_item((k < 8) ? 8'hff : 8'h00, k == MAX_PATTERN_BYTES - 1, 1'b0);
    end

    // Random phases; one of them runs with no gaps and no stalls on either side.
    for (k = 0; k < 8; k++) begin
      full_rate = (k == 5);
      random_phase(235, k == 0);
    end

    settle();
    full_rate = 1'b0;
    if (doc_results_due.size() != 0) begin
      errors += doc_results_due.size();
      $display("%0d document results never arrived", doc_results_due.size());
    end
    $display("summary: %0d text items in %0d documents, %0d with a match, %0d register writes",
             items_taken, documents_done, found_docs, cfg_writes);
    $display("summary: empty, oversized and full-length patterns, case folding, mid-document");
    $display("  pattern changes, full-rate and stalled traffic; %0d bad results", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
